@@ rtl/core/stpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared types and constants for the sorted task priority queue.
// ----------------------------------------------------------------------------
package stpq_pkg;

   localparam int MODE_W   = 2;
   localparam int ID_W     = 8;
   localparam int DAYS_W   = 10;
   localparam int WEIGHT_W = 10;
   localparam int HOURS_W  = 12;
   localparam int SCORE_W  = 23;
   localparam int STATUS_W = 2;
   localparam int NUM_W    = WEIGHT_W + 16;
   localparam int DEN_W    = 24;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]     task_id;
      logic [SCORE_W-1:0]  score;
      logic [DAYS_W-1:0]   days_left;
      logic [WEIGHT_W-1:0] weight_tenths;
      logic [HOURS_W-1:0]  hours_tenths;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/core/stpq_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpq_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stpq_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [stpq_pkg::NUM_W-1:0]   numerator,
   input  logic [stpq_pkg::DEN_W-1:0]   denominator,
   output logic                         done,
   output logic [stpq_pkg::SCORE_W-1:0] quotient
);
   import stpq_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[SCORE_W-1:0];

endmodule

@@ rtl/core/sorted_insert_task_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_task_priority_queue
// Bounded sorted task table held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  req     | in        | tdata: mode, task_id, days_left, weight_tenths, hours_tenths
//  rsp     | out       | tdata: status, task_id, score, days, weight, hours; tlast
//  csr     | in        | wdata: order_by_deadline
//
//  insert: denominator product formed at the accept edge, divider started in
//  S_MUL, 26 quotient bits produced in S_DIV, then a scan of the table (S_SRD
//  and S_SCMP per entry passed, S_SRD once more on reaching the end) and a
//  shift-down (S_MRD and S_MWR per moved entry, S_MRD for the final write)
//  through the memory, one access at a time; read-out: S_RDRD and S_RDOUT per
//  entry, S_RDRD waiting while a held beat is not taken; clear: answered at
//  the accept. One item at a time; req_tready is low while busy or while a
//  result waits. Synchronous reset empties the table at once via the count.
// ----------------------------------------------------------------------------
module sorted_insert_task_priority_queue #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode, task_id, days_left, weight_tenths, hours_tenths (42 bits + pad)
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, out_task_id, out_score, out_days_left, out_weight_tenths,
   // out_hours_tenths (65 bits + pad)
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_wdata
);
   import stpq_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL   = 9'b000000010,
      S_DIV   = 9'b000000100,
      S_SRD   = 9'b000001000,
      S_SCMP  = 9'b000010000,
      S_MRD   = 9'b000100000,
      S_MWR   = 9'b001000000,
      S_RDRD  = 9'b010000000,
      S_RDOUT = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 order_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   entry_type            new_ff, new_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic                 out_valid_ff, out_valid_in;
   logic [71:0]          out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;

   entry_type            mem [TABLE_DEPTH];
   entry_type            rd_data_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr, mem_raddr;
   entry_type            mem_wdata;
   logic                 mem_re;

   logic                 div_start, div_done;
   logic [SCORE_W-1:0]   div_q;
   logic                 ahead;

   stpq_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   ({new_ff.weight_tenths, 16'h0000}),
      .denominator (den_ff),
      .done        (div_done),
      .quotient    (div_q)
   );

   function automatic logic [71:0] pack_rsp(status_type st, entry_type e);
      return {7'd0, e.hours_tenths, e.weight_tenths, e.days_left, e.score,
              e.task_id, st};
   endfunction

   assign ahead = order_ff ? (rd_data_ff.days_left < new_ff.days_left)
                           : (rd_data_ff.score > new_ff.score);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      new_in       = new_ff;
      den_in       = den_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[IDX_W-1:0];
      mem_wdata    = new_ff;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff[IDX_W-1:0];
      div_start    = 1'b0;
      req_tready   = (state_ff == S_IDLE) && !out_valid_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               unique case (mode_type'(req_tdata[1:0]))
                  MODE_INSERT: begin
                     new_in.task_id       = req_tdata[9:2];
                     new_in.days_left     = req_tdata[19:10];
                     new_in.weight_tenths = req_tdata[29:20];
                     new_in.hours_tenths  = req_tdata[41:30];
                     new_in.score         = '0;
                     den_in = DEN_W'((DEN_W'(req_tdata[19:10]) + DEN_W'(1))
                              * (DEN_W'(req_tdata[41:30]) + DEN_W'(10)));
                     state_in = S_MUL;
                  end
                  MODE_READ: begin
                     if (count_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_data_in  = pack_rsp(ST_EMPTY, '0);
                        out_last_in  = 1'b1;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_RDRD;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     out_valid_in = 1'b1;
                     out_data_in  = pack_rsp(ST_CLEARED, '0);
                     out_last_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            // divider takes its operands from the captured task copy
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               new_in.score = div_q;
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  out_valid_in = 1'b1;
                  out_data_in  = pack_rsp(ST_FULL, new_in);
                  out_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SRD;
               end
            end
         end
         S_SRD: begin
            if (ptr_ff == count_ff) begin
               // position found at end; now shift from count down to ptr
               ptr_in   = count_ff;
               state_in = S_MRD;
            end else begin
               mem_re   = 1'b1;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (ahead) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_SRD;
            end else begin
               // remember insert point in den_ff, start moving from the top
               den_in   = DEN_W'(ptr_ff);
               ptr_in   = count_ff;
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            if (ptr_ff == CNT_W'(den_ff)) begin
               mem_we       = 1'b1;
               count_in     = count_ff + 1'b1;
               out_valid_in = 1'b1;
               out_data_in  = pack_rsp(ST_OK, new_ff);
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = IDX_W'(ptr_ff - 1'b1);
               state_in  = S_MWR;
            end
         end
         S_MWR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_ff - 1'b1;
            state_in  = S_MRD;
         end
         S_RDRD: begin
            if (!out_valid_ff || rsp_tready) begin
               mem_re   = 1'b1;
               state_in = S_RDOUT;
            end
         end
         S_RDOUT: begin
            out_valid_in = 1'b1;
            out_data_in  = pack_rsp(ST_OK, rd_data_ff);
            out_last_in  = (ptr_ff + 1'b1) == count_ff;
            ptr_in       = ptr_ff + 1'b1;
            state_in     = out_last_in ? S_IDLE : S_RDRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the scan reaching count means insert at the end
   logic [DEN_W-1:0] den_fix;
   always_comb begin
      den_fix = den_in;
      if (state_ff == S_SRD && ptr_ff == count_ff) den_fix = DEN_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_wen) order_ff <= csr_wdata;
      end
      ptr_ff      <= ptr_in;
      new_ff      <= new_in;
      den_ff      <= den_fix;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ test/sorted_insert_task_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_task_priority_queue_tb
// Self-checking bench for the sorted task table: directed corner cases, then
// random insert / read-out / clear traffic under three back-pressure profiles
// and both sort orders, checked beat by beat against a behavioural table.
// ----------------------------------------------------------------------------
module sorted_insert_task_priority_queue_tb;
   import stpq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int SETTLE      = 120;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      status_type status;
      entry_type  ent;
      logic       last;
   } rsp_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wen;
   logic        csr_wdata;

   entry_type    sorted_tasks[DEPTH];
   int           task_count;
   logic         by_deadline;
   rsp_beat_type awaited_beats[$];
   int           error_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           quiet_cycles;

   sorted_insert_task_priority_queue #(.TABLE_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [SCORE_W-1:0] q16_score(logic [WEIGHT_W-1:0] w,
                                                    logic [DAYS_W-1:0] d,
                                                    logic [HOURS_W-1:0] h);
      logic [63:0] num;
      logic [63:0] den;
      num = 64'(w) << 16;
      den = (64'(d) + 64'd1) * (64'(h) + 64'd10);
      return SCORE_W'(num / den);
   endfunction

   function automatic void push_beat(status_type s, entry_type e, logic l);
      rsp_beat_type b;
      b.status = s;
      b.ent    = e;
      b.last   = l;
      awaited_beats.push_back(b);
   endfunction

   // update the table copy and queue the beats an accepted item should produce
   function automatic void table_update(mode_type m, entry_type n);
      int pos;
      case (m)
         MODE_INSERT: begin
            n.score = q16_score(n.weight_tenths, n.days_left, n.hours_tenths);
            if (task_count >= DEPTH) begin
               push_beat(ST_FULL, n, 1'b1);
            end else begin
               pos = 0;
               while (pos < task_count &&
                      (by_deadline ? sorted_tasks[pos].days_left < n.days_left
                                   : sorted_tasks[pos].score > n.score))
                  pos++;
               for (int i = task_count; i > pos; i--)
                  sorted_tasks[i] = sorted_tasks[i-1];
               sorted_tasks[pos] = n;
               task_count++;
               push_beat(ST_OK, n, 1'b1);
            end
         end
         MODE_READ: begin
            if (task_count == 0)
               push_beat(ST_EMPTY, '0, 1'b1);
            for (int i = 0; i < task_count; i++)
               push_beat(ST_OK, sorted_tasks[i], i == task_count - 1);
         end
         MODE_CLEAR: begin
            task_count = 0;
            push_beat(ST_CLEARED, '0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(mode_type m, logic [ID_W-1:0] id, logic [DAYS_W-1:0] d,
                            logic [WEIGHT_W-1:0] w, logic [HOURS_W-1:0] h);
      entry_type n;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, h, w, d, id, m};
      do @(posedge clock); while (!req_tready);
      n.task_id       = id;
      n.score         = '0;
      n.days_left     = d;
      n.weight_tenths = w;
      n.hours_tenths  = h;
      table_update(m, n);
   endtask

   task automatic send_insert(logic [ID_W-1:0] id, logic [DAYS_W-1:0] d,
                              logic [WEIGHT_W-1:0] w, logic [HOURS_W-1:0] h);
      send_item(MODE_INSERT, id, d, w, h);
   endtask

   task automatic send_cmd(mode_type m);
      send_item(m, ID_W'($urandom), DAYS_W'($urandom), WEIGHT_W'($urandom),
                HOURS_W'($urandom));
   endtask

   // let every awaited beat arrive, then allow the block to finish silent work
   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_order(logic v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      by_deadline = v;
   endtask

   // response checker and receiver back-pressure
   always @(posedge clock) begin
      rsp_beat_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_beats.size() == 0) begin
            $error("unexpected response beat: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            exp_b = awaited_beats.pop_front();
            if (rsp_tdata[1:0] !== exp_b.status) begin
               $error("status: expected %0d, got %0d", exp_b.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[9:2] !== exp_b.ent.task_id) begin
               $error("out_task_id: expected %0d, got %0d", exp_b.ent.task_id,
                      rsp_tdata[9:2]);
               error_count++;
            end
            if (rsp_tdata[32:10] !== exp_b.ent.score) begin
               $error("out_score: expected %0d, got %0d", exp_b.ent.score,
                      rsp_tdata[32:10]);
               error_count++;
            end
            if (rsp_tdata[42:33] !== exp_b.ent.days_left) begin
               $error("out_days_left: expected %0d, got %0d", exp_b.ent.days_left,
                      rsp_tdata[42:33]);
               error_count++;
            end
            if (rsp_tdata[52:43] !== exp_b.ent.weight_tenths) begin
               $error("out_weight_tenths: expected %0d, got %0d",
                      exp_b.ent.weight_tenths, rsp_tdata[52:43]);
               error_count++;
            end
            if (rsp_tdata[64:53] !== exp_b.ent.hours_tenths) begin
               $error("out_hours_tenths: expected %0d, got %0d",
                      exp_b.ent.hours_tenths, rsp_tdata[64:53]);
               error_count++;
            end
            if (rsp_tlast !== exp_b.last) begin
               $error("last: expected %0d, got %0d", exp_b.last, rsp_tlast);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("sorted_insert_task_priority_queue regression: fail");
         $finish;
      end
   end

   task automatic test_empty_and_clear();
      send_cmd(MODE_READ);
      send_cmd(MODE_CLEAR);
      send_cmd(MODE_NOP);
      send_cmd(MODE_READ);
   endtask

   task automatic test_score_extremes();
      send_insert(8'd255, 10'd0, 10'd1000, 12'd0);
      send_insert(8'd0, 10'd1023, 10'd0, 12'd4095);
      send_insert(8'd1, 10'd1023, 10'd1000, 12'd4095);
      send_insert(8'd2, 10'd0, 10'd1, 12'd4095);
      // equal score: newcomer must land ahead of the older one
      send_insert(8'd3, 10'd0, 10'd1000, 12'd0);
      send_cmd(MODE_READ);
   endtask

   task automatic test_fill_to_full();
      for (int i = 0; i < DEPTH - 5 + 2; i++)
         send_insert(8'(16 + i), DAYS_W'($urandom_range(0, 1023)),
                     WEIGHT_W'($urandom_range(0, 1000)), HOURS_W'($urandom_range(0, 4095)));
      send_cmd(MODE_READ);
   endtask

   task automatic test_order_switch();
      drain();
      write_order(1'b1);
      // table keeps score order; new entries go before first not-earlier deadline
      send_insert(8'd40, 10'd5, 10'd500, 12'd20);
      send_cmd(MODE_CLEAR);
      send_insert(8'd41, 10'd7, 10'd10, 12'd1);
      send_insert(8'd42, 10'd7, 10'd900, 12'd1);
      send_insert(8'd43, 10'd0, 10'd900, 12'd1);
      send_cmd(MODE_READ);
      send_cmd(MODE_CLEAR);
   endtask

   task automatic random_phase(int items);
      int sel;
      for (int k = 0; k < items; k++) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            if ($urandom_range(3) == 0)
               send_insert(ID_W'($urandom), DAYS_W'($urandom_range(0, 3)),
                           WEIGHT_W'($urandom_range(0, 1000)),
                           HOURS_W'($urandom_range(0, 4095)));
            else
               send_insert(ID_W'($urandom), DAYS_W'($urandom_range(0, 1023)),
                           WEIGHT_W'($urandom_range(0, 1000)),
                           HOURS_W'($urandom_range(0, 4095)));
         end else if (sel < 86) begin
            send_cmd(MODE_READ);
         end else if (sel < 96) begin
            send_cmd(MODE_CLEAR);
         end else begin
            send_cmd(MODE_NOP);
         end
      end
   endtask

   task automatic test_random_traffic();
      drain();
      write_order(1'b0);
      send_idle_pct = 22;
      recv_idle_pct = 63;
      random_phase(150);
      drain();
      write_order(1'b1);
      send_idle_pct = 63;
      recv_idle_pct = 22;
      random_phase(150);
      drain();
      write_order(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(150);
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_wdata     = 1'b0;
      task_count    = 0;
      by_deadline   = 1'b0;
      error_count   = 0;
      quiet_cycles  = 0;
      send_idle_pct = 22;
      recv_idle_pct = 63;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_order(1'b0);

      test_empty_and_clear();
      test_score_extremes();
      test_fill_to_full();
      test_order_switch();
      test_random_traffic();

      if (error_count == 0)
         $display("sorted_insert_task_priority_queue regression: pass");
      else
         $display("sorted_insert_task_priority_queue regression: fail");
      $finish;
   end

endmodule
